// ----- hw/rtl/spf_pkg.sv -----
`default_nettype none

package spf_pkg;

   localparam logic [7:0] CMD_RUMBLE = 8'h72;
   localparam logic [7:0] CMD_FORMAT = 8'h62;

   localparam logic [7:0] FMT_STANDARD = 8'd0;
   localparam logic [7:0] FMT_EXT8     = 8'd1;
   localparam logic [7:0] FMT_NIBBLE   = 8'd2;

   localparam logic MODE_PAD   = 1'b0;
   localparam logic MODE_MOUSE = 1'b1;

   localparam logic CSR_DEVICE_MODE   = 1'b0;
   localparam logic CSR_RUMBLE_ENABLE = 1'b1;

   localparam logic [7:0] TRIGGER_LIMIT = 8'd16;

   typedef struct packed {
      logic [15:0]        buttons;
      logic [15:0]        button_force_mask;
      logic [7:0]         extra_byte2;
      logic [7:0]         extra_byte3;
      logic [7:0]         extra_byte4;
      logic [7:0]         extra_byte5;
      logic [7:0]         extra_byte6;
      logic [7:0]         extra_byte7;
      logic signed [15:0] mouse_dx;
      logic signed [15:0] mouse_dy;
      logic [23:0]        received_bits;
   } spf_req_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] left;
      logic [3:0] right;
   } spf_rumble_type;

endpackage

`default_nettype wire

// ----- hw/rtl/spf_channels.sv -----
`default_nettype none

interface spf_req_if;
   logic               valid;
   logic               ready;
   logic [15:0]        buttons;
   logic [15:0]        button_force_mask;
   logic [7:0]         extra_byte2;
   logic [7:0]         extra_byte3;
   logic [7:0]         extra_byte4;
   logic [7:0]         extra_byte5;
   logic [7:0]         extra_byte6;
   logic [7:0]         extra_byte7;
   logic signed [15:0] mouse_dx;
   logic signed [15:0] mouse_dy;
   logic [23:0]        received_bits;

   modport source (
      output valid, buttons, button_force_mask, extra_byte2, extra_byte3, extra_byte4,
             extra_byte5, extra_byte6, extra_byte7, mouse_dx, mouse_dy, received_bits,
      input  ready
   );
   modport sink (
      input  valid, buttons, button_force_mask, extra_byte2, extra_byte3, extra_byte4,
             extra_byte5, extra_byte6, extra_byte7, mouse_dx, mouse_dy, received_bits,
      output ready
   );
endinterface

interface spf_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] shift_word;
   logic        rumble_valid;
   logic [3:0]  rumble_left;
   logic [3:0]  rumble_right;

   modport source (
      output valid, shift_word, rumble_valid, rumble_left, rumble_right,
      input  ready
   );
   modport sink (
      input  valid, shift_word, rumble_valid, rumble_left, rumble_right,
      output ready
   );
endinterface

`default_nettype wire

// ----- hw/rtl/spf_word_build.sv -----
`default_nettype none

module spf_word_build
   import spf_pkg::*;
(
   input  wire spf_req_type item,
   input  wire logic        device_mode,
   input  wire logic [7:0]  report_format,
   output logic [63:0]      shift_word
);

   // saturate to -128..127, then inverted sign-magnitude
   function automatic logic [7:0] axis_code(input logic signed [15:0] v);
      logic [7:0] mag;
      begin
         mag = 8'(-v);
         if (v > 16'sd127) begin
            axis_code = 8'h80;
         end else if (v < -16'sd128) begin
            axis_code = 8'h00;
         end else if (v < 16'sd0) begin
            axis_code = ~(mag | 8'h80);
         end else begin
            axis_code = ~v[7:0];
         end
      end
   endfunction

   logic [15:0] pad_bits;
   logic [15:0] std_bits;

   always_comb begin
      pad_bits = item.buttons | item.button_force_mask;
      std_bits = pad_bits;
      if (~item.extra_byte6 > TRIGGER_LIMIT) begin
         std_bits[13] = 1'b0;
      end
      if (~item.extra_byte7 > TRIGGER_LIMIT) begin
         std_bits[12] = 1'b0;
      end
   end

   always_comb begin
      shift_word = '0;
      if (device_mode == MODE_MOUSE) begin
         shift_word[7:0]   = 8'hFF;
         shift_word[15:8]  = item.buttons[15:8];
         shift_word[23:16] = axis_code(item.mouse_dx);
         shift_word[31:24] = axis_code(item.mouse_dy);
      end else begin
         unique case (report_format)
            FMT_EXT8: begin
               shift_word[7:0]   = pad_bits[7:0];
               shift_word[15:8]  = {pad_bits[15:12], 4'h9};
               shift_word[23:16] = item.extra_byte2;
               shift_word[31:24] = item.extra_byte3;
               shift_word[39:32] = item.extra_byte4;
               shift_word[47:40] = item.extra_byte5;
               shift_word[55:48] = item.extra_byte6;
               shift_word[63:56] = item.extra_byte7;
            end
            FMT_NIBBLE: begin
               shift_word[7:0]   = pad_bits[7:0];
               shift_word[15:8]  = {pad_bits[15:12], 4'h8};
               shift_word[23:16] = {item.extra_byte2[7:4], item.extra_byte3[7:4]};
               shift_word[31:24] = {item.extra_byte4[7:4], item.extra_byte5[7:4]};
               shift_word[39:32] = {item.extra_byte6[7:4], item.extra_byte7[7:4]};
            end
            default: begin
               // any unknown format falls back to standard
               shift_word[7:0]  = std_bits[7:0];
               shift_word[15:8] = std_bits[15:8] | 8'h0F;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/spf_cmd_decode.sv -----
`default_nettype none

module spf_cmd_decode
   import spf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        advance,
   input  wire logic        rumble_enable,
   input  wire logic [23:0] received_bits,
   output logic [7:0]       report_format,
   output spf_rumble_type   rumble
);

   logic [7:0] report_format_ff;
   logic [7:0] report_format_in;
   logic [7:0] last_rumble_ff;
   logic [7:0] last_rumble_in;
   logic [7:0] shifted_cmd;
   logic [7:0] shifted_data;
   logic [7:0] cmd;
   logic [7:0] cmd_arg;
   logic       is_format;
   logic       is_rumble;

   always_comb begin
      // commands may arrive one bit late in the frame
      shifted_cmd  = {received_bits[22:16], received_bits[15]};
      shifted_data = {received_bits[14:8], received_bits[7]};
      if (shifted_cmd == CMD_RUMBLE || shifted_cmd == CMD_FORMAT) begin
         cmd     = shifted_cmd;
         cmd_arg = shifted_data;
      end else begin
         cmd     = received_bits[23:16];
         cmd_arg = received_bits[15:8];
      end
      is_format = (cmd == CMD_FORMAT);
      is_rumble = (cmd == CMD_RUMBLE);
   end

   always_comb begin
      rumble.valid = is_rumble && rumble_enable && (cmd_arg != last_rumble_ff);
      rumble.left  = rumble.valid ? cmd_arg[7:4] : 4'h0;
      rumble.right = rumble.valid ? cmd_arg[3:0] : 4'h0;
   end

   always_comb begin
      report_format_in = report_format_ff;
      last_rumble_in   = last_rumble_ff;
      if (advance && is_format) begin
         report_format_in = cmd_arg;
      end
      if (advance && is_rumble) begin
         last_rumble_in = cmd_arg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         report_format_ff <= FMT_STANDARD;
         last_rumble_ff   <= 8'h00;
      end else begin
         report_format_ff <= report_format_in;
         last_rumble_ff   <= last_rumble_in;
      end
   end

   assign report_format = report_format_ff;

   a_format_update: assert property (@(posedge clock) disable iff (reset)
      (advance && is_format) |=> report_format_ff == $past(cmd_arg))
      else $error("report format not taken from format command");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(report_format_ff) && $stable(last_rumble_ff))
      else $error("command state changed without a transaction");

   a_rumble_track: assert property (@(posedge clock) disable iff (reset)
      (advance && rumble.valid) |=>
         last_rumble_ff == {$past(rumble.left), $past(rumble.right)})
      else $error("last rumble does not match reported rumble");

endmodule

`default_nettype wire

// ----- hw/rtl/snes_pad_report_formatter_unit.sv -----
`default_nettype none

// SNES pad report formatter for one controller port. One request transaction per console
// latch; the response carries the 64-bit word to shift out next plus any rumble change.
// The word uses the report format in force before the received command of the same latch.
// The request is held in an input register, then one pass of word build and command
// decode fills the response register. One transaction is accepted every cycle while the
// response side keeps up; a stalled response holds the input register, and ready drops
// only when both registers are full and the response is not taken.
// device_mode and rumble_enable are written through the csr port; the user writes them only
// while no transaction is in flight, which the block itself does not enforce.
module snes_pad_report_formatter_unit
   import spf_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   spf_req_if.sink    req_chan,
   spf_rsp_if.source  rsp_chan,
   input  wire logic  csr_write_enable,
   input  wire logic  csr_index,
   input  wire logic  csr_write_data
);

   logic           device_mode_ff;
   logic           rumble_enable_ff;
   logic           stage_valid_ff;
   logic           stage_valid_in;
   spf_req_type    stage_item_ff;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic [63:0]    shift_word_ff;
   spf_rumble_type rumble_ff;
   logic           rsp_free;
   logic           advance;
   logic           req_take;
   logic [7:0]     report_format;
   logic [63:0]    shift_word;
   spf_rumble_type rumble;

   always_ff @(posedge clock) begin
      if (reset) begin
         device_mode_ff   <= MODE_PAD;
         rumble_enable_ff <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DEVICE_MODE:   device_mode_ff   <= csr_write_data;
            CSR_RUMBLE_ENABLE: rumble_enable_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign advance        = stage_valid_ff && rsp_free;
   assign req_chan.ready = !stage_valid_ff || rsp_free;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_take) begin
         stage_valid_in = 1'b1;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_item_ff.buttons           <= req_chan.buttons;
         stage_item_ff.button_force_mask <= req_chan.button_force_mask;
         stage_item_ff.extra_byte2       <= req_chan.extra_byte2;
         stage_item_ff.extra_byte3       <= req_chan.extra_byte3;
         stage_item_ff.extra_byte4       <= req_chan.extra_byte4;
         stage_item_ff.extra_byte5       <= req_chan.extra_byte5;
         stage_item_ff.extra_byte6       <= req_chan.extra_byte6;
         stage_item_ff.extra_byte7       <= req_chan.extra_byte7;
         stage_item_ff.mouse_dx          <= req_chan.mouse_dx;
         stage_item_ff.mouse_dy          <= req_chan.mouse_dy;
         stage_item_ff.received_bits     <= req_chan.received_bits;
      end
      if (advance) begin
         shift_word_ff <= shift_word;
         rumble_ff     <= rumble;
      end
   end

   spf_word_build u_word_build (
      .item          (stage_item_ff),
      .device_mode   (device_mode_ff),
      .report_format (report_format),
      .shift_word    (shift_word)
   );

   spf_cmd_decode u_cmd_decode (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .rumble_enable (rumble_enable_ff),
      .received_bits (stage_item_ff.received_bits),
      .report_format (report_format),
      .rumble        (rumble)
   );

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.shift_word   = shift_word_ff;
   assign rsp_chan.rumble_valid = rumble_ff.valid;
   assign rsp_chan.rumble_left  = rumble_ff.left;
   assign rsp_chan.rumble_right = rumble_ff.right;

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !stage_valid_ff && !rsp_valid_ff)
      else $error("pipeline not empty after reset");

   a_take_fills: assert property (@(posedge clock) disable iff (reset)
      req_take |=> stage_valid_ff)
      else $error("accepted transaction lost from input register");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && !rsp_free) |=> stage_valid_ff && rsp_valid_ff
         && $stable(stage_item_ff))
      else $error("input register changed while response stalled");

   a_advance_shows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced transaction did not reach the response register");

endmodule

`default_nettype wire

// ----- tb/sv/tb_snes_pad_report_formatter_unit.sv -----
module tb_snes_pad_report_formatter_unit;
   import spf_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 1000;
   localparam int HOLD_OFF_CYCLES = 80;

   typedef struct packed {
      logic [63:0] shift_word;
      logic        rumble_valid;
      logic [3:0]  rumble_left;
      logic [3:0]  rumble_right;
   } latch_report_type;

   typedef enum logic [1:0] {READY_STEADY, READY_RANDOM, READY_PERIODIC} ready_pattern_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic csr_index;
   logic csr_write_data;

   spf_req_if req_if ();
   spf_rsp_if rsp_if ();

   snes_pad_report_formatter_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // predictor copy of registers and block state
   logic       cfg_device_mode;
   logic       cfg_rumble_enable;
   logic [7:0] active_format;
   logic [7:0] prev_rumble;

   latch_report_type pending_reports[$];
   int               mismatch_count;
   int               burst_left;
   int               stalled_cycles;
   int               hold_off_asked;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [7:0] encode_axis(input logic signed [15:0] move);
      logic [15:0] mag;
      mag = -move;
      if (move > 127) return 8'h80;
      if (move < -128) return 8'h00;
      if (move < 0) return ~(mag[7:0] | 8'h80);
      return ~move[7:0];
   endfunction

   function automatic latch_report_type build_report(input spf_req_type item);
      latch_report_type rpt;
      logic [15:0]      pressed;
      logic [7:0]       inv_left, inv_right, b2, b3, b4, op, arg;
      rpt = '0;
      if (cfg_device_mode == MODE_MOUSE) begin
         rpt.shift_word[31:0] = {encode_axis(item.mouse_dy), encode_axis(item.mouse_dx),
                                 item.buttons[15:8], 8'hFF};
      end else begin
         pressed = item.buttons | item.button_force_mask;
         case (active_format)
            FMT_EXT8: begin
               rpt.shift_word = {item.extra_byte7, item.extra_byte6, item.extra_byte5,
                                 item.extra_byte4, item.extra_byte3, item.extra_byte2,
                                 pressed[15:12], 4'h9, pressed[7:0]};
            end
            FMT_NIBBLE: begin
               rpt.shift_word = {24'h0,
                                 item.extra_byte6[7:4], item.extra_byte7[7:4],
                                 item.extra_byte4[7:4], item.extra_byte5[7:4],
                                 item.extra_byte2[7:4], item.extra_byte3[7:4],
                                 pressed[15:12], 4'h8, pressed[7:0]};
            end
            default: begin
               // analog triggers pressed past the limit release the digital shoulders
               inv_left  = ~item.extra_byte6;
               inv_right = ~item.extra_byte7;
               if (inv_left > TRIGGER_LIMIT) pressed[13] = 1'b0;
               if (inv_right > TRIGGER_LIMIT) pressed[12] = 1'b0;
               rpt.shift_word = {48'h0, pressed[15:12], 4'hF, pressed[7:0]};
            end
         endcase
      end

      // command may arrive one bit late; fall back to byte aligned decode
      b2  = item.received_bits[23:16];
      b3  = item.received_bits[15:8];
      b4  = item.received_bits[7:0];
      op  = {b2[6:0], b3[7]};
      arg = {b3[6:0], b4[7]};
      if (op != CMD_RUMBLE && op != CMD_FORMAT) begin
         op  = b2;
         arg = b3;
      end
      if (op == CMD_FORMAT) begin
         active_format = arg;
      end else if (op == CMD_RUMBLE) begin
         if (arg != prev_rumble && cfg_rumble_enable) begin
            rpt.rumble_valid = 1'b1;
            rpt.rumble_left  = arg[7:4];
            rpt.rumble_right = arg[3:0];
         end
         prev_rumble = arg;
      end
      return rpt;
   endfunction

   function automatic logic [23:0] command_bits(input logic [7:0] op, input logic [7:0] arg,
                                                input bit late);
      logic [6:0] filler;
      logic [7:0] tail;
      filler = 7'($urandom_range(0, 127));
      tail   = 8'($urandom_range(0, 255));
      if (late) return {1'b0, op, arg, filler};
      return {op, arg, tail};
   endfunction

   function automatic spf_req_type random_latch();
      spf_req_type item;
      logic [7:0]  arg;
      item.buttons           = 16'($urandom);
      item.button_force_mask = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h0;
      item.extra_byte2       = 8'($urandom);
      item.extra_byte3       = 8'($urandom);
      item.extra_byte4       = 8'($urandom);
      item.extra_byte5       = 8'($urandom);
      item.extra_byte6       = $urandom_range(0, 1) ? 8'($urandom_range(8'hE8, 8'hFF))
                                                    : 8'($urandom);
      item.extra_byte7       = $urandom_range(0, 1) ? 8'($urandom_range(8'hE8, 8'hFF))
                                                    : 8'($urandom);
      case ($urandom_range(0, 2))
         0: begin
            item.mouse_dx = 16'($urandom);
            item.mouse_dy = 16'($urandom);
         end
         1: begin
            item.mouse_dx = 16'($urandom_range(0, 400) - 200);
            item.mouse_dy = 16'($urandom_range(0, 400) - 200);
         end
         default: begin
            item.mouse_dx = 16'($urandom_range(0, 6) + 16'hFF7E);
            item.mouse_dy = 16'($urandom_range(0, 6) + 16'h007C);
         end
      endcase
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            arg = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
            item.received_bits = command_bits(CMD_FORMAT, arg, 1'($urandom_range(0, 1)));
         end
         3, 4, 5: begin
            arg = ($urandom_range(0, 2) == 0) ? prev_rumble : 8'($urandom);
            item.received_bits = command_bits(CMD_RUMBLE, arg, 1'($urandom_range(0, 1)));
         end
         default: item.received_bits = 24'($urandom);
      endcase
      return item;
   endfunction

   task automatic drive_latch(input spf_req_type item);
      req_if.valid             <= 1'b1;
      req_if.buttons           <= item.buttons;
      req_if.button_force_mask <= item.button_force_mask;
      req_if.extra_byte2       <= item.extra_byte2;
      req_if.extra_byte3       <= item.extra_byte3;
      req_if.extra_byte4       <= item.extra_byte4;
      req_if.extra_byte5       <= item.extra_byte5;
      req_if.extra_byte6       <= item.extra_byte6;
      req_if.extra_byte7       <= item.extra_byte7;
      req_if.mouse_dx          <= item.mouse_dx;
      req_if.mouse_dy          <= item.mouse_dy;
      req_if.received_bits     <= item.received_bits;
      do @(posedge clock); while (!req_if.ready);
      pending_reports.push_back(build_report(item));
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(0, 8);
      end
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_register(input logic idx, input logic value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_DEVICE_MODE) cfg_device_mode = value;
      else cfg_rumble_enable = value;
      @(posedge clock);
   endtask

   task automatic test_standard_pad();
      spf_req_type item;
      item = '0;
      drive_latch(item);
      item.buttons     = 16'hFFFF;
      item.extra_byte6 = 8'hFF;
      item.extra_byte7 = 8'hFF;
      drive_latch(item);
      // trigger exactly at the limit keeps its shoulder, one past clears it
      item.buttons     = 16'h3000;
      item.extra_byte6 = 8'hEF;
      item.extra_byte7 = 8'hEE;
      drive_latch(item);
      item.buttons           = 16'h0000;
      item.button_force_mask = 16'hFFFF;
      item.extra_byte2       = 8'hFF;
      item.extra_byte3       = 8'hFF;
      item.extra_byte4       = 8'hFF;
      item.extra_byte5       = 8'hFF;
      item.extra_byte6       = 8'hEE;
      item.extra_byte7       = 8'hEF;
      drive_latch(item);
      item.buttons           = 16'h5A5A;
      item.button_force_mask = 16'h0101;
      drive_latch(item);
   endtask

   task automatic test_report_formats();
      spf_req_type item;
      item = random_latch();
      item.received_bits = command_bits(CMD_FORMAT, FMT_EXT8, 1'b1);
      drive_latch(item);
      item = '1;
      item.received_bits = 24'h0;
      drive_latch(item);
      item = '0;
      drive_latch(item);
      item = random_latch();
      item.received_bits = command_bits(CMD_FORMAT, FMT_NIBBLE, 1'b0);
      drive_latch(item);
      item = '1;
      item.received_bits = 24'h0;
      drive_latch(item);
      item = random_latch();
      item.received_bits = command_bits(CMD_FORMAT, 8'd7, 1'b1);
      drive_latch(item);
      // unknown formats fall back to standard
      item = random_latch();
      item.received_bits = command_bits(CMD_FORMAT, 8'hFF, 1'b0);
      drive_latch(item);
      item = random_latch();
      item.received_bits = command_bits(CMD_FORMAT, FMT_STANDARD, 1'b1);
      drive_latch(item);
   endtask

   task automatic test_rumble_reports();
      spf_req_type item;
      // disabled rumble still tracks the last value
      item = random_latch();
      item.received_bits = command_bits(CMD_RUMBLE, 8'h5A, 1'b1);
      drive_latch(item);
      wait_drained();
      program_register(CSR_RUMBLE_ENABLE, 1'b1);
      item.received_bits = command_bits(CMD_RUMBLE, 8'h5A, 1'b0);
      drive_latch(item);
      item.received_bits = command_bits(CMD_RUMBLE, 8'hA5, 1'b1);
      drive_latch(item);
      item.received_bits = command_bits(CMD_RUMBLE, 8'h00, 1'b0);
      drive_latch(item);
      item.received_bits = command_bits(CMD_RUMBLE, 8'hFF, 1'b1);
      drive_latch(item);
      item.received_bits = command_bits(CMD_RUMBLE, 8'hFF, 1'b0);
      drive_latch(item);
   endtask

   task automatic test_mouse_axes();
      spf_req_type item;
      wait_drained();
      program_register(CSR_DEVICE_MODE, MODE_MOUSE);
      item = '0;
      item.buttons           = 16'hA5FF;
      item.button_force_mask = 16'hFFFF;
      item.mouse_dx          = 16'sd127;
      item.mouse_dy          = 16'sd128;
      drive_latch(item);
      item.mouse_dx = -16'sd128;
      item.mouse_dy = -16'sd129;
      drive_latch(item);
      item.mouse_dx = 16'sd0;
      item.mouse_dy = -16'sd1;
      drive_latch(item);
      item.mouse_dx = 16'sh7FFF;
      item.mouse_dy = 16'sh8000;
      drive_latch(item);
      item.mouse_dx = -16'sd127;
      item.mouse_dy = 16'sd1;
      item.received_bits = command_bits(CMD_FORMAT, FMT_EXT8, 1'b1);
      drive_latch(item);
   endtask

   task automatic test_random_traffic();
      logic [1:0] settings[5];
      settings = '{2'b01, 2'b11, 2'b00, 2'b10, 2'b01};
      foreach (settings[i]) begin
         wait_drained();
         program_register(CSR_DEVICE_MODE, settings[i][1]);
         program_register(CSR_RUMBLE_ENABLE, settings[i][0]);
         repeat (95) drive_latch(random_latch());
      end
   endtask

   task automatic test_backpressure();
      hold_off_asked++;
      burst_left = 40;
      repeat (30) drive_latch(random_latch());
      wait_drained();
      repeat (10) drive_latch(random_latch());
   endtask

   initial begin : response_monitor
      latch_report_type  want;
      ready_pattern_type pattern;
      int                hold_left, pattern_left, pattern_period, pattern_count;
      int                hold_off_served;
      rsp_if.ready    = 1'b0;
      hold_left       = 0;
      pattern_left    = 0;
      pattern_period  = 4;
      pattern_count   = 0;
      hold_off_served = 0;
      pattern         = READY_STEADY;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            if (pending_reports.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected transaction, shift_word %h",
                        $time, rsp_if.shift_word);
            end else begin
               want = pending_reports.pop_front();
               if (rsp_if.shift_word !== want.shift_word ||
                   rsp_if.rumble_valid !== want.rumble_valid ||
                   rsp_if.rumble_left !== want.rumble_left ||
                   rsp_if.rumble_right !== want.rumble_right) begin
                  mismatch_count++;
                  $display("%0t: expected %h rumble %b/%h/%h, got %h rumble %b/%h/%h",
                           $time, want.shift_word, want.rumble_valid, want.rumble_left,
                           want.rumble_right, rsp_if.shift_word, rsp_if.rumble_valid,
                           rsp_if.rumble_left, rsp_if.rumble_right);
               end
            end
         end
         if (hold_off_asked != hold_off_served) begin
            hold_left       = HOLD_OFF_CYCLES;
            hold_off_served = hold_off_asked;
         end
         if (pattern_left == 0) begin
            case ($urandom_range(0, 2))
               0:       pattern = READY_STEADY;
               1:       pattern = READY_RANDOM;
               default: pattern = READY_PERIODIC;
            endcase
            pattern_period = $urandom_range(2, 7);
            pattern_left   = $urandom_range(20, 150);
         end else begin
            pattern_left--;
         end
         pattern_count++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            case (pattern)
               READY_STEADY: rsp_if.ready <= 1'b1;
               READY_RANDOM: rsp_if.ready <= ($urandom_range(0, 2) != 0);
               default:      rsp_if.ready <= (pattern_count % pattern_period != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   initial begin
      reset                    = 1'b1;
      csr_write_enable         = 1'b0;
      csr_index                = CSR_DEVICE_MODE;
      csr_write_data           = 1'b0;
      req_if.valid             = 1'b0;
      req_if.buttons           = '0;
      req_if.button_force_mask = '0;
      req_if.extra_byte2       = '0;
      req_if.extra_byte3       = '0;
      req_if.extra_byte4       = '0;
      req_if.extra_byte5       = '0;
      req_if.extra_byte6       = '0;
      req_if.extra_byte7       = '0;
      req_if.mouse_dx          = '0;
      req_if.mouse_dy          = '0;
      req_if.received_bits     = '0;
      cfg_device_mode          = MODE_PAD;
      cfg_rumble_enable        = 1'b0;
      active_format            = FMT_STANDARD;
      prev_rumble              = 8'h00;
      burst_left               = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_standard_pad();
      test_report_formats();
      test_rumble_reports();
      test_mouse_axes();
      test_random_traffic();
      test_backpressure();

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_reports.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
